// ===== rtl/core/egcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared widths and defaults for the extended gcd / modular inverse block.
// ----------------------------------------------------------------------------
package egcd_pkg;

    localparam int VALUE_W              = 31;
    localparam int GCD_W                = 31;
    localparam int COEF_W               = 32;
    localparam int OPERAND_BITS_DEFAULT = 31;

endpackage

// ===== rtl/core/egcd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_in_if
// Operand channel: value and modulus with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface egcd_in_if
    import egcd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);
endinterface

// ===== rtl/core/egcd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_out_if
// Result channel: gcd, Bezout coefficients and inverse with valid/ready.
// ----------------------------------------------------------------------------
interface egcd_out_if
    import egcd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [GCD_W-1:0]         gcd;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [COEF_W-1:0] coef_modulus;
    logic [GCD_W-1:0]         inverse;
    logic                     inverse_exists;

    modport source (output valid, output gcd, output coef_value, output coef_modulus,
                    output inverse, output inverse_exists, input ready);
    modport sink   (input valid, input gcd, input coef_value, input coef_modulus,
                    input inverse, input inverse_exists, output ready);
endinterface

// ===== rtl/core/extended_gcd_mod_inverse_top.sv =====
// From the accepting edge, each quotient step doubles the divisor in ST_ALIGN, then
// subtracts and halves it in ST_REDUCE in the single shift-and-subtract unit, and
// ST_FINISH writes the result register once the last quotient step is done.
// Only one item is worked on at a time: a new item is taken only back in ST_IDLE.
// The result register lets a new item be taken while the previous result waits.
// Reset (rst_n, asynchronous, active low) empties the result register and idles.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_mod_inverse_top
// Extended Euclidean algorithm with modular inverse, using one shared
// shift-and-subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
module extended_gcd_mod_inverse_top
    import egcd_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    egcd_in_if.sink    operands,
    egcd_out_if.source results
);

    localparam int W  = (OPERAND_BITS < VALUE_W) ? OPERAND_BITS : VALUE_W;
    localparam int CW = W + 2;
    localparam int KW = $clog2(W);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ALIGN  = 2'd1;
    localparam logic [1:0] ST_REDUCE = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic signed [CW-1:0] COEF_ZERO = '0;
    localparam logic signed [CW-1:0] COEF_ONE  = CW'(1);

    logic [1:0]           state_reg, state_next;
    logic [W-1:0]         rem_reg, rem_next;
    logic [W-1:0]         r1_reg, r1_next;
    logic [W-1:0]         d_reg, d_next;
    logic [W-1:0]         mod_reg, mod_next;
    logic [KW-1:0]        k_reg, k_next;
    logic signed [CW-1:0] s0_reg, s0_next;
    logic signed [CW-1:0] s1_reg, s1_next;
    logic signed [CW-1:0] ds_reg, ds_next;
    logic signed [CW-1:0] t0_reg, t0_next;
    logic signed [CW-1:0] t1_reg, t1_next;
    logic signed [CW-1:0] dt_reg, dt_next;

    logic                     out_valid_reg, out_valid_next;
    logic [GCD_W-1:0]         gcd_reg, gcd_next;
    logic signed [COEF_W-1:0] coef_value_reg, coef_value_next;
    logic signed [COEF_W-1:0] coef_modulus_reg, coef_modulus_next;
    logic [GCD_W-1:0]         inverse_reg, inverse_next;
    logic                     exists_reg, exists_next;

    logic                 accept;
    logic                 can_shift;
    logic                 fits;
    logic [W-1:0]         rem_sub;
    logic signed [CW-1:0] s_sub;
    logic signed [CW-1:0] t_sub;
    logic signed [CW-1:0] inv_sum;
    logic signed [CW-1:0] inv_val;
    logic                 exists;

    assign accept = operands.valid && operands.ready;

    // The shared unit: a doubling test for alignment and a conditional subtract
    // of the aligned divisor, applied to the remainder and both coefficients.
    assign can_shift = !d_reg[W-1] && ({d_reg, 1'b0} <= {1'b0, rem_reg});
    assign fits      = d_reg <= rem_reg;
    assign rem_sub   = fits ? rem_reg - d_reg : rem_reg;
    assign s_sub     = fits ? s0_reg - ds_reg : s0_reg;
    assign t_sub     = fits ? t0_reg - dt_reg : t0_reg;

    // With gcd one the coefficient lies strictly inside (-m, m), so a single
    // add of the modulus normalises it.
    assign inv_sum = s0_reg + $signed({2'b00, mod_reg});
    assign inv_val = s0_reg[CW-1] ? inv_sum : s0_reg;
    assign exists  = (rem_reg == W'(1)) && (mod_reg != '0);

    always_comb
    begin
        state_next        = state_reg;
        rem_next          = rem_reg;
        r1_next           = r1_reg;
        d_next            = d_reg;
        mod_next          = mod_reg;
        k_next            = k_reg;
        s0_next           = s0_reg;
        s1_next           = s1_reg;
        ds_next           = ds_reg;
        t0_next           = t0_reg;
        t1_next           = t1_reg;
        dt_next           = dt_reg;
        out_valid_next    = out_valid_reg && !results.ready;
        gcd_next          = gcd_reg;
        coef_value_next   = coef_value_reg;
        coef_modulus_next = coef_modulus_reg;
        inverse_next      = inverse_reg;
        exists_next       = exists_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rem_next = operands.value[W-1:0];
                    r1_next  = operands.modulus[W-1:0];
                    d_next   = operands.modulus[W-1:0];
                    mod_next = operands.modulus[W-1:0];
                    k_next   = '0;
                    s0_next  = COEF_ONE;
                    s1_next  = COEF_ZERO;
                    ds_next  = COEF_ZERO;
                    t0_next  = COEF_ZERO;
                    t1_next  = COEF_ONE;
                    dt_next  = COEF_ONE;
                    state_next = (operands.modulus[W-1:0] == '0) ? ST_FINISH : ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                if (can_shift)
                begin
                    d_next  = {d_reg[W-2:0], 1'b0};
                    ds_next = ds_reg <<< 1;
                    dt_next = dt_reg <<< 1;
                    k_next  = k_reg + KW'(1);
                end
                else
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (k_reg == '0)
                begin
                    // Quotient complete: rotate the remainder and coefficient pairs.
                    rem_next = r1_reg;
                    r1_next  = rem_sub;
                    d_next   = rem_sub;
                    s0_next  = s1_reg;
                    s1_next  = s_sub;
                    ds_next  = s_sub;
                    t0_next  = t1_reg;
                    t1_next  = t_sub;
                    dt_next  = t_sub;
                    state_next = (rem_sub == '0) ? ST_FINISH : ST_ALIGN;
                end
                else
                begin
                    rem_next = rem_sub;
                    s0_next  = s_sub;
                    t0_next  = t_sub;
                    d_next   = d_reg >> 1;
                    ds_next  = ds_reg >>> 1;
                    dt_next  = dt_reg >>> 1;
                    k_next   = k_reg - KW'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next    = 1'b1;
                    gcd_next          = GCD_W'(rem_reg);
                    coef_value_next   = COEF_W'(s0_reg);
                    coef_modulus_next = COEF_W'(t0_reg);
                    inverse_next      = exists ? GCD_W'(inv_val[W-1:0]) : '0;
                    exists_next       = exists;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg          <= rem_next;
        r1_reg           <= r1_next;
        d_reg            <= d_next;
        mod_reg          <= mod_next;
        s0_reg           <= s0_next;
        s1_reg           <= s1_next;
        ds_reg           <= ds_next;
        t0_reg           <= t0_next;
        t1_reg           <= t1_next;
        dt_reg           <= dt_next;
        gcd_reg          <= gcd_next;
        coef_value_reg   <= coef_value_next;
        coef_modulus_reg <= coef_modulus_next;
        inverse_reg      <= inverse_next;
        exists_reg       <= exists_next;
    end

    assign operands.ready         = (state_reg == ST_IDLE);
    assign results.valid          = out_valid_reg;
    assign results.gcd            = gcd_reg;
    assign results.coef_value     = coef_value_reg;
    assign results.coef_modulus   = coef_modulus_reg;
    assign results.inverse        = inverse_reg;
    assign results.inverse_exists = exists_reg;

    // A new result appears only as the sequencer leaves its finishing state.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result became valid outside the finishing state");

    // While reducing, the remainder always stays below twice the aligned divisor.
    a_reduce_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REDUCE |-> {1'b0, rem_reg} < {d_reg, 1'b0})
        else $error("remainder escaped the aligned divisor bound");

    // An accepted item always starts the sequencer.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_ALIGN || state_reg == ST_FINISH)
        else $error("accepted item did not start the sequencer");

    // An inverse is only flagged alongside a gcd of one.
    a_exists_gcd_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && exists_reg |-> gcd_reg == GCD_W'(1))
        else $error("inverse flagged with a gcd other than one");

endmodule

// ===== dv/extended_gcd_mod_inverse_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_mod_inverse_top_test
// Self-checking bench for the extended gcd / modular inverse block. Operand
// items are sent over the input channel and predicted on acceptance. Each
// result item is checked field by field against the oldest prediction. The
// stimulus covers directed corner operands, a back-to-back run, a long output
// stall and a random mix, with random idling on both channels.
// ----------------------------------------------------------------------------
module extended_gcd_mod_inverse_top_test;
    import egcd_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PRINT_LIMIT  = 100;
    localparam int STEP_LIMIT   = 2 * OPERAND_BITS_DEFAULT + 4;

    typedef struct {
        logic [GCD_W-1:0]         gcd;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [COEF_W-1:0] coef_modulus;
        logic [GCD_W-1:0]         inverse;
        logic                     inverse_exists;
    } egcd_result_t;

    logic clk = 1'b0;
    logic rst_n;

    egcd_in_if  opnd();
    egcd_out_if rslt();

    extended_gcd_mod_inverse_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (opnd),
        .results  (rslt)
    );

    egcd_result_t pending_results[$];
    int           mismatch_count = 0;
    bit           steady         = 1'b0;
    bit           hold_request   = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Extended Euclid on 64-bit words; the coefficients wrap as two's complement.
    function automatic egcd_result_t predict_egcd(input logic [VALUE_W-1:0] a_in,
                                                  input logic [VALUE_W-1:0] m_in);
        bit [63:0]    mask;
        bit [63:0]    m;
        bit [63:0]    r0, r1, s0, s1, t0, t1;
        bit [63:0]    q, nr, ns, nt, mag, rem, inv;
        bit           neg;
        int           step;
        egcd_result_t res;
        mask = (64'd1 << OPERAND_BITS_DEFAULT) - 64'd1;
        r0   = {33'd0, a_in} & mask;
        m    = {33'd0, m_in} & mask;
        r1   = m;
        s0   = 64'd1;
        s1   = 64'd0;
        t0   = 64'd0;
        t1   = 64'd1;
        for (step = 0; step < STEP_LIMIT && r1 != 64'd0; step++)
        begin
            q  = r0 / r1;
            nr = r0 - q * r1;
            ns = s0 - q * s1;
            nt = t0 - q * t1;
            r0 = r1;
            r1 = nr;
            s0 = s1;
            s1 = ns;
            t0 = t1;
            t1 = nt;
        end
        inv                = 64'd0;
        res.inverse_exists = 1'b0;
        if (r0 == 64'd1 && m != 64'd0)
        begin
            neg = s0[63];
            mag = neg ? (64'd0 - s0) : s0;
            rem = mag % m;
            inv = (neg && rem != 64'd0) ? (m - rem) : rem;
            res.inverse_exists = 1'b1;
        end
        res.gcd          = r0[GCD_W-1:0];
        res.coef_value   = s0[COEF_W-1:0];
        res.coef_modulus = t0[COEF_W-1:0];
        res.inverse      = inv[GCD_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                     want);
    endtask

    // Holds valid and the operands until the block accepts the item.
    task automatic send_operands(input logic [VALUE_W-1:0] v, input logic [VALUE_W-1:0] m);
        while (!steady && $urandom_range(99) < 17)
        begin
            opnd.valid <= 1'b0;
            @(posedge clk);
        end
        opnd.valid   <= 1'b1;
        opnd.value   <= v;
        opnd.modulus <= m;
        @(posedge clk);
        while (!opnd.ready)
            @(posedge clk);
        pending_results.push_back(predict_egcd(v, m));
    endtask

    task automatic pick_random_operands(output logic [VALUE_W-1:0] v,
                                        output logic [VALUE_W-1:0] m);
        int unsigned kind;
        int unsigned g;
        int unsigned w;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            v = VALUE_W'($urandom);
            m = VALUE_W'($urandom);
        end
        else if (kind < 60)
        begin
            // A shared factor, so the gcd is above one and no inverse exists.
            g = $urandom_range(1000, 2);
            v = VALUE_W'(g * $urandom_range(32'h7fff_ffff / g, 1));
            m = VALUE_W'(g * $urandom_range(32'h7fff_ffff / g, 1));
        end
        else if (kind < 75)
        begin
            v = VALUE_W'($urandom_range(255, 1));
            m = VALUE_W'($urandom_range(255, 1));
        end
        else if (kind < 85)
        begin
            case ($urandom_range(3))
                0:       begin v = VALUE_W'($urandom); m = VALUE_W'(1); end
                1:       begin v = VALUE_W'(1); m = VALUE_W'($urandom); end
                2:
                begin
                    m = VALUE_W'($urandom_range(4000, 1));
                    v = VALUE_W'(m * $urandom_range(1000, 1));
                end
                default: begin v = VALUE_W'($urandom); m = v; end
            endcase
        end
        else if (kind < 90)
        begin
            case ($urandom_range(2))
                0:       begin v = '0; m = VALUE_W'($urandom); end
                1:       begin v = VALUE_W'($urandom); m = '0; end
                default: begin v = '0; m = VALUE_W'($urandom_range(1)); end
            endcase
        end
        else
        begin
            w = $urandom_range(31, 1);
            v = VALUE_W'($urandom & ((32'd1 << w) - 32'd1));
            w = $urandom_range(31, 1);
            m = VALUE_W'($urandom & ((32'd1 << w) - 32'd1));
        end
    endtask

    task automatic test_corner_operands();
        send_operands(31'd1, 31'd1);
        send_operands(31'h7fff_ffff, 31'd1);
        send_operands(31'd0, 31'd7);
        send_operands(31'd0, 31'd1);
        send_operands(31'd1, 31'd0);
        send_operands(31'd12345, 31'd0);
        send_operands(31'd0, 31'd0);
        send_operands(31'h7fff_ffff, 31'h7fff_ffff);
        send_operands(31'h7fff_ffff, 31'h7fff_fffe);
        send_operands(31'h7fff_fffe, 31'h7fff_ffff);
        // Consecutive Fibonacci numbers take the longest run of quotient steps.
        send_operands(31'd1134903170, 31'd1836311903);
        send_operands(31'd1836311903, 31'd1134903170);
        send_operands(31'd6, 31'd9);
        send_operands(31'd17, 31'd5);
        send_operands(31'd3, 31'd7);
        send_operands(31'h4000_0000, 31'h7fff_ffff);
        send_operands(31'd100, 31'd25);
        send_operands(31'd2, 31'h7fff_ffff);
        send_operands(31'h5555_5555, 31'h2aaa_aaaa);
        send_operands(31'h2aaa_aaaa, 31'h5555_5555);
        send_operands(31'h4000_0000, 31'h4000_0000);
    endtask

    task automatic test_back_to_back();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] m;
        steady = 1'b1;
        repeat (60)
        begin
            pick_random_operands(v, m);
            send_operands(v, m);
        end
        steady = 1'b0;
    endtask

    task automatic test_result_stall();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] m;
        hold_request = 1'b1;
        repeat (10)
        begin
            pick_random_operands(v, m);
            send_operands(v, m);
        end
        wait (!hold_request);
    endtask

    task automatic test_random_mix();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] m;
        repeat (520)
        begin
            pick_random_operands(v, m);
            send_operands(v, m);
        end
    endtask

    // Result sink: random idling, or one long hold-off when asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rslt.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            else
                rslt.ready <= steady || ($urandom_range(99) >= 17);
        end
    end

    initial
    begin
        egcd_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rslt.valid && rslt.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result item", 64'(rslt.gcd), 64'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (rslt.gcd !== want.gcd)
                        report_mismatch("gcd", 64'(rslt.gcd), 64'(want.gcd));
                    if (rslt.coef_value !== want.coef_value)
                        report_mismatch("coef_value", 64'(rslt.coef_value),
                                        64'(want.coef_value));
                    if (rslt.coef_modulus !== want.coef_modulus)
                        report_mismatch("coef_modulus", 64'(rslt.coef_modulus),
                                        64'(want.coef_modulus));
                    if (rslt.inverse !== want.inverse)
                        report_mismatch("inverse", 64'(rslt.inverse), 64'(want.inverse));
                    if (rslt.inverse_exists !== want.inverse_exists)
                        report_mismatch("inverse_exists", 64'(rslt.inverse_exists),
                                        64'(want.inverse_exists));
                end
            end
        end
    end

    // Ends the run when no item moves on either channel for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((opnd.valid && opnd.ready) || (rslt.valid && rslt.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        opnd.valid   <= 1'b0;
        opnd.value   <= '0;
        opnd.modulus <= '0;
        rslt.ready   <= 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_operands();
        test_back_to_back();
        test_result_stall();
        test_random_mix();

        opnd.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
